[hw/rtl/fdb_pkg.sv]
// Shared constants, control-word types and the microcode table of the
// feedback delay with biquad. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdb_pkg;

    localparam int CHANNELS    = 2;
    localparam int CH_BITS     = $clog2(CHANNELS);
    localparam int MAX_DELAY   = 65536;
    localparam int POS_BITS    = $clog2(MAX_DELAY);
    localparam int ADDR_W      = CH_BITS + POS_BITS;
    localparam int SAMPLE_BITS = 24;
    localparam int LEN_W       = 17;
    localparam int GAIN_W      = 16;
    localparam int COEF_W      = 24;
    localparam int MUL_W       = SAMPLE_BITS + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int COEF_FRAC   = 20;
    localparam int GAIN_FRAC   = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int STEP_W      = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_IN_LOOP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2        = 3'd7;

    localparam logic [LEN_W-1:0]  RST_DELAY_LENGTH = 17'd24000;
    localparam logic [GAIN_W-1:0] RST_GAIN         = 16'd16384;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // microprogram step addresses
    localparam logic [STEP_W-1:0] ST_READ   = 4'd0;
    localparam logic [STEP_W-1:0] ST_MUL_X0 = 4'd1;
    localparam logic [STEP_W-1:0] ST_MUL_X1 = 4'd2;
    localparam logic [STEP_W-1:0] ST_MUL_X2 = 4'd3;
    localparam logic [STEP_W-1:0] ST_MUL_Y1 = 4'd4;
    localparam logic [STEP_W-1:0] ST_MUL_Y2 = 4'd5;
    localparam logic [STEP_W-1:0] ST_ACC_Y2 = 4'd6;
    localparam logic [STEP_W-1:0] ST_FILT   = 4'd7;
    localparam logic [STEP_W-1:0] ST_MUL_FB = 4'd8;
    localparam logic [STEP_W-1:0] ST_WRITE  = 4'd9;
    localparam logic [STEP_W-1:0] ST_EMIT   = 4'd10;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_B_X0,
        MUL_B_X1,
        MUL_B_X2,
        MUL_A1_Y1,
        MUL_A2_Y2,
        MUL_FB,
        MUL_MIX
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD2,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     mem_rd;
        logic     mem_wr;
        logic     filt;
        logic     emit;
        logic     last;
    } t_uop;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    // Control store: one word per step. The product of step n is consumed
    // by the accumulator, a delay memory write or the output register in step n+1.
    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        u.mul_sel = MUL_NONE;
        u.acc_op  = ACC_HOLD;
        u.mem_rd  = 1'b0;
        u.mem_wr  = 1'b0;
        u.filt    = 1'b0;
        u.emit    = 1'b0;
        u.last    = 1'b0;
        unique case (step)
            ST_READ:   u.mem_rd = 1'b1;
            ST_MUL_X0: u.mul_sel = MUL_B_X0;
            ST_MUL_X1: begin
                u.mul_sel = MUL_B_X1;
                u.acc_op  = ACC_LOAD;
            end
            ST_MUL_X2: begin
                u.mul_sel = MUL_B_X2;
                u.acc_op  = ACC_ADD2;
            end
            ST_MUL_Y1: begin
                u.mul_sel = MUL_A1_Y1;
                u.acc_op  = ACC_ADD;
            end
            ST_MUL_Y2: begin
                u.mul_sel = MUL_A2_Y2;
                u.acc_op  = ACC_SUB;
            end
            ST_ACC_Y2: u.acc_op = ACC_SUB;
            ST_FILT:   u.filt = 1'b1;
            ST_MUL_FB: u.mul_sel = MUL_FB;
            ST_WRITE: begin
                u.mem_wr  = 1'b1;
                u.mul_sel = MUL_MIX;
            end
            ST_EMIT: begin
                u.emit = 1'b1;
                u.last = 1'b1;
            end
            default:   u.last = 1'b1;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/fdb_if.sv]
// Handshake channels of the feedback delay: sample input, sample output
// and register writes. Depends on fdb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fdb_in_if;
    import fdb_pkg::*;
    logic                          valid;
    logic                          ready;
    logic [CH_BITS-1:0]            channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          frame_end;
    modport source (output valid, output channel, output sample_in, output frame_end,
                    input ready);
    modport sink   (input valid, input channel, input sample_in, input frame_end,
                    output ready);
endinterface

interface fdb_out_if;
    import fdb_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface fdb_cfg_if;
    import fdb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/fdb_spram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fdb_spram #(
    parameter int ADDR_W = 17,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/feedback_delay_with_biquad.sv]
// Feedback delay with a per-channel lowpass biquad, sequenced from a control store.
// The single 25x25 multiplier steps through the microprogram for one item at a time;
// input is not ready until the current item has finished its last step.
// A finished result waits in the output register while the next item is taken.
// Reset: registers to defaults, filter history to zero, then a clear pass
// writes all 131072 words of the delay memory to zero; input is not ready meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module feedback_delay_with_biquad (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fdb_in_if.sink     i_in,
    fdb_out_if.source  o_out,
    fdb_cfg_if.sink    i_cfg
);
    import fdb_pkg::*;

    // configuration
    logic [LEN_W-1:0]         r_len;
    logic [GAIN_W-1:0]        r_fb_gain;
    logic [GAIN_W-1:0]        r_mix;
    logic                     r_rev;
    logic                     r_filt_loop;
    logic signed [COEF_W-1:0] r_kb;
    logic signed [COEF_W-1:0] r_a1;
    logic signed [COEF_W-1:0] r_a2;

    // sequencer
    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    logic                r_clr;
    logic [ADDR_W-1:0]   r_clr_addr;
    t_uop                w_uop;

    // item and position
    logic [CH_BITS-1:0]            r_ch;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_fe;
    logic [POS_BITS-1:0]           r_pos;
    logic [POS_BITS-1:0]           r_rd_pos;
    logic [POS_BITS-1:0]           r_wr_pos;

    // datapath
    logic signed [MUL_W-1:0]       w_mul_a;
    logic signed [MUL_W-1:0]       w_mul_b;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       w_prod_ext;
    logic signed [ACC_W-1:0]       w_x_ext;
    logic signed [ACC_W-1:0]       w_scaled;
    logic signed [SAMPLE_BITS-1:0] w_scaled_sat;
    logic signed [SAMPLE_BITS-1:0] w_filt_val;
    logic signed [SAMPLE_BITS-1:0] r_filt;
    logic signed [SAMPLE_BITS-1:0] w_fb_src;
    logic signed [SAMPLE_BITS-1:0] w_mem_q;
    logic [SAMPLE_BITS-1:0]        w_ram_q;

    logic signed [SAMPLE_BITS-1:0] r_hx1 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_hx2 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_hy1 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_hy2 [CHANNELS];

    // output
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    // memory port
    logic                          w_ram_we;
    logic                          w_ram_re;
    logic [ADDR_W-1:0]             w_ram_addr;
    logic [SAMPLE_BITS-1:0]        w_ram_wdata;

    logic                w_in_acc;
    logic                w_out_busy;
    logic                w_hold;
    logic                w_emit;
    logic [LEN_W-1:0]    w_len_eff;
    logic [POS_BITS-1:0] w_pos_eff;
    logic [LEN_W-1:0]    w_mirror;
    logic [POS_BITS-1:0] w_wpos;
    logic [LEN_W-1:0]    w_inc;
    logic [POS_BITS-1:0] n_pos;
    logic [STEP_W-1:0]   n_step;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = ~r_busy & ~r_clr;
    assign w_in_acc    = i_in.valid & i_in.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out;

    assign w_uop      = uop_rom(r_step);
    assign w_out_busy = r_out_valid & ~o_out.ready;
    assign w_hold     = w_uop.emit & w_out_busy;
    assign w_emit     = r_busy & w_uop.emit & ~w_out_busy;
    assign n_step     = r_step + STEP_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= RST_DELAY_LENGTH;
            r_fb_gain   <= RST_GAIN;
            r_mix       <= RST_GAIN;
            r_rev       <= 1'b0;
            r_filt_loop <= 1'b0;
            r_kb        <= '0;
            r_a1        <= '0;
            r_a2        <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_DELAY_LENGTH:   r_len       <= i_cfg.data[LEN_W-1:0];
                REG_FEEDBACK_GAIN:  r_fb_gain   <= i_cfg.data[GAIN_W-1:0];
                REG_MIX_GAIN:       r_mix       <= i_cfg.data[GAIN_W-1:0];
                REG_REVERSE_MODE:   r_rev       <= i_cfg.data[0];
                REG_FILTER_IN_LOOP: r_filt_loop <= i_cfg.data[0];
                REG_COEF_B:         r_kb        <= signed'(i_cfg.data[COEF_W-1:0]);
                REG_COEF_A1:        r_a1        <= signed'(i_cfg.data[COEF_W-1:0]);
                REG_COEF_A2:        r_a2        <= signed'(i_cfg.data[COEF_W-1:0]);
            endcase
        end
    end

    // loop length clamp, read position, mirrored write position, next position
    always_comb begin
        if (r_len == '0) begin
            w_len_eff = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_DELAY)) begin
            w_len_eff = LEN_W'(MAX_DELAY);
        end else begin
            w_len_eff = r_len;
        end
        w_pos_eff = ({1'b0, r_pos} >= w_len_eff) ? '0 : r_pos;
        w_mirror  = w_len_eff - LEN_W'(1) - {1'b0, w_pos_eff};
        w_wpos    = r_rev ? w_mirror[POS_BITS-1:0] : w_pos_eff;
        w_inc     = {1'b0, r_rd_pos} + LEN_W'(1);
        if (!r_fe) begin
            n_pos = r_rd_pos;
        end else if (w_inc >= w_len_eff) begin
            n_pos = '0;
        end else begin
            n_pos = w_inc[POS_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= ST_READ;
            r_clr       <= 1'b1;
            r_clr_addr  <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == '1) begin
                    r_clr <= 1'b0;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc) begin
                r_busy <= 1'b1;
                r_step <= ST_READ;
            end else if (r_busy && !w_hold) begin
                if (w_uop.emit) begin
                    r_pos <= n_pos;
                end
                if (w_uop.last) begin
                    r_busy <= 1'b0;
                    r_step <= ST_READ;
                end else begin
                    r_step <= n_step;
                end
            end
        end
    end

    // latch the item and its positions, and the result on emit
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ch     <= i_in.channel;
            r_x      <= i_in.sample_in;
            r_fe     <= i_in.frame_end;
            r_rd_pos <= w_pos_eff;
            r_wr_pos <= w_wpos;
        end
        if (w_emit) begin
            r_out <= w_scaled_sat;
        end
    end

    // multiplier operand select
    assign w_mem_q  = signed'(w_ram_q);
    assign w_fb_src = r_filt_loop ? r_filt : w_mem_q;

    always_comb begin
        unique case (w_uop.mul_sel)
            MUL_B_X0: begin
                w_mul_a = MUL_W'(r_kb);
                w_mul_b = MUL_W'(w_mem_q);
            end
            MUL_B_X1: begin
                w_mul_a = MUL_W'(r_kb);
                w_mul_b = MUL_W'(r_hx1[r_ch]);
            end
            MUL_B_X2: begin
                w_mul_a = MUL_W'(r_kb);
                w_mul_b = MUL_W'(r_hx2[r_ch]);
            end
            MUL_A1_Y1: begin
                w_mul_a = MUL_W'(r_a1);
                w_mul_b = MUL_W'(r_hy1[r_ch]);
            end
            MUL_A2_Y2: begin
                w_mul_a = MUL_W'(r_a2);
                w_mul_b = MUL_W'(r_hy2[r_ch]);
            end
            MUL_FB: begin
                w_mul_a = MUL_W'(w_fb_src);
                w_mul_b = signed'({{(MUL_W - GAIN_W){1'b0}}, r_fb_gain});
            end
            MUL_MIX: begin
                w_mul_a = MUL_W'(r_filt);
                w_mul_b = signed'({{(MUL_W - GAIN_W){1'b0}}, r_mix});
            end
            MUL_NONE: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod_ext   = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_x_ext      = {{(ACC_W - SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x};
    assign w_scaled     = w_x_ext + (w_prod_ext >>> GAIN_FRAC);
    assign w_scaled_sat = sat_sample(w_scaled);
    assign w_filt_val   = sat_sample(r_acc >>> COEF_FRAC);

    always_ff @(posedge i_clk) begin
        // hold the mix product while the result waits for the output register
        if (!w_hold) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (r_busy) begin
            unique case (w_uop.acc_op)
                ACC_LOAD: r_acc <= w_prod_ext;
                ACC_ADD:  r_acc <= r_acc + w_prod_ext;
                ACC_ADD2: r_acc <= r_acc + (w_prod_ext <<< 1);
                ACC_SUB:  r_acc <= r_acc - w_prod_ext;
                ACC_HOLD: r_acc <= r_acc;
                default:  r_acc <= r_acc;
            endcase
        end
    end

    // filter output and per-channel history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_hx1[c] <= '0;
                r_hx2[c] <= '0;
                r_hy1[c] <= '0;
                r_hy2[c] <= '0;
            end
        end else if (r_busy && w_uop.filt) begin
            r_hx2[r_ch] <= r_hx1[r_ch];
            r_hx1[r_ch] <= w_mem_q;
            r_hy2[r_ch] <= r_hy1[r_ch];
            r_hy1[r_ch] <= w_filt_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && w_uop.filt) begin
            r_filt <= w_filt_val;
        end
    end

    // delay memory port: clear pass, then item read and write
    always_comb begin
        w_ram_we    = r_clr | (r_busy & w_uop.mem_wr);
        w_ram_re    = ~r_clr & r_busy & w_uop.mem_rd;
        w_ram_wdata = r_clr ? '0 : w_scaled_sat;
        if (r_clr) begin
            w_ram_addr = r_clr_addr;
        end else if (w_uop.mem_wr) begin
            w_ram_addr = {r_ch, r_wr_pos};
        end else begin
            w_ram_addr = {r_ch, r_rd_pos};
        end
    end

    fdb_spram #(
        .ADDR_W (ADDR_W),
        .DATA_W (SAMPLE_BITS)
    ) u_delay_mem (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_q)
    );

endmodule

`default_nettype wire
